@@ design/multilevel_feedback_task_scheduler_defines.svh @@
// Assertion macros shared by the scheduler RTL.
// Expects clk and arst_n in the scope of every use.
`ifndef MULTILEVEL_FEEDBACK_TASK_SCHEDULER_DEFINES_SVH
`define MULTILEVEL_FEEDBACK_TASK_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define MFTS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define MFTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

@@ design/mfts_pkg.sv @@
// Types and constants for the task scheduler.
// No dependencies; imported by every scheduler module except mfts_ram.
package mfts_pkg;

	typedef enum logic [2:0] {
		CMD_ENQUEUE  = 3'd0,
		CMD_SCHEDULE = 3'd1,
		CMD_TICK     = 3'd2,
		CMD_YIELD    = 3'd3,
		CMD_DEQUEUE  = 3'd4,
		CMD_INSTALL  = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_ACTIVE = 3'd1,
		ST_IDLE_PROT = 3'd2,
		ST_ALREADY   = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_PUSH,
		S_PICK,
		S_POP1,
		S_POP2,
		S_DIV
	} bstate_t;

	localparam logic [1:0] CFG_IDLE_SLOT    = 2'd0;
	localparam logic [1:0] CFG_INIT_QUANTUM = 2'd1;
	localparam logic [1:0] CFG_TICKS_WINDOW = 2'd2;

	localparam int unsigned LOAD_SCALE = 100;
	localparam int unsigned QUOT_BITS  = 7;

	typedef struct packed {
		cmd_t       cmd;
		logic       slot_ok;
		logic [5:0] task_id;
		logic [3:0] prio;
	} item_t;

	typedef struct packed {
		logic [5:0]  idle_slot;
		logic [7:0]  init_quantum;
		logic [15:0] ticks_per_window;
	} cfg_t;

	typedef struct packed {
		logic        start;
		logic [23:0] num;
		logic [16:0] den;
	} div_req_t;

	typedef struct packed {
		logic       busy;
		logic       done;
		logic [6:0] quot;
	} div_rsp_t;

	typedef struct packed {
		status_t    status;
		logic [5:0] task_out;
		logic       task_valid;
		logic [6:0] ready_count;
		logic [6:0] load_percent;
		logic       reschedule_pending;
	} res_t;

endpackage

@@ design/mfts_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfts_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

@@ design/mfts_div.sv @@
// Iterative load divider: one quotient bit per cycle, quotient below 128.
// Depends on mfts_pkg.
module mfts_div (
	input  logic               clk,
	input  logic               arst_n,
	input  mfts_pkg::div_req_t req,
	output mfts_pkg::div_rsp_t rsp
);
	import mfts_pkg::*;

	logic                 busy_q, done_q;
	logic [2:0]           cnt_q;
	logic [23:0]          rem_q, dsh_q;
	logic [QUOT_BITS-1:0] quot_q;
	logic                 ge;

	assign ge = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'(QUOT_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == 3'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 3'd1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.num;
			dsh_q  <= 24'(req.den) << (QUOT_BITS - 1);
			quot_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quot_q <= {quot_q[QUOT_BITS-2:0], ge};
			dsh_q  <= dsh_q >> 1;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
endmodule

@@ design/mfts_front.sv @@
// Front end: accepts commands, classifies them, holds them in a two-entry queue.
// Depends on mfts_pkg and the assertion macro header.
`include "multilevel_feedback_task_scheduler_defines.svh"
module mfts_front #(
	parameter int unsigned NUM_TASKS    = 64,
	parameter int unsigned MAX_PRIORITY = 15
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [15:0]     in_data,
	output logic            q_valid,
	output mfts_pkg::item_t q_item,
	input  logic            q_pop
);
	import mfts_pkg::*;

	item_t      cls;
	item_t      buf_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;

	// classify: range-check the slot, saturate the priority
	always_comb begin
		cls.cmd     = cmd_t'(in_data[2:0]);
		cls.task_id = in_data[8:3];
		cls.slot_ok = 32'(in_data[8:3]) < NUM_TASKS;
		cls.prio    = (32'(in_data[12:9]) > MAX_PRIORITY) ? 4'(MAX_PRIORITY) : in_data[12:9];
	end

	assign in_ready = cnt_q != 2'd2;
	assign push     = in_valid && in_ready;
	assign q_valid  = cnt_q != 2'd0;
	assign q_item   = buf_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= cls;
		end
	end

	`MFTS_ASSERT_IMPL(a_pop_nonempty, q_pop, cnt_q != 2'd0, "pop from empty command queue")
	`MFTS_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q != 2'd3, "command queue count out of range")
	`MFTS_ASSERT_NEXT(a_push_grows, push && !q_pop, cnt_q == $past(cnt_q) + 2'd1, "push lost")
endmodule

@@ design/mfts_back.sv @@
// Back end: sequencer over the task and queue tables, tick accounting, results.
// Depends on mfts_pkg, mfts_ram, mfts_div and the assertion macro header.
`include "multilevel_feedback_task_scheduler_defines.svh"
module mfts_back #(
	parameter int unsigned NUM_TASKS    = 64,
	parameter int unsigned MAX_PRIORITY = 15,
	parameter int unsigned QUANTUM_BITS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  mfts_pkg::item_t q_item,
	output logic            q_pop,
	input  mfts_pkg::cfg_t  cfg,
	output logic            res_valid,
	input  logic            res_ready,
	output mfts_pkg::res_t  res
);
	import mfts_pkg::*;

	localparam int unsigned TW   = $clog2(NUM_TASKS);
	localparam int unsigned NQ   = MAX_PRIORITY + 1;
	localparam int unsigned PW   = $clog2(NQ);
	localparam int unsigned QW   = QUANTUM_BITS;
	localparam int unsigned RW   = PW + QW;
	localparam int unsigned QMAX = (1 << QW) - 1;

	bstate_t        state_q, state_d;
	item_t          cur_q, cur_d;
	logic           res_valid_q, res_valid_d;
	status_t        res_status_q, res_status_d;
	logic [NQ-1:0]  qne_q, qne_d;
	logic [TW-1:0]  act_task_q, act_task_d;
	logic           act_valid_q, act_valid_d;
	logic [PW-1:0]  act_prio_q, act_prio_d;
	logic [QW-1:0]  act_quant_q, act_quant_d;
	logic           act_resched_q, act_resched_d;
	logic [6:0]     wait_q, wait_d;
	logic [15:0]    idle_cnt_q, idle_cnt_d, busy_cnt_q, busy_cnt_d, phase_q, phase_d;
	logic [6:0]     load_q, load_d;
	logic [TW-1:0]  push_slot_q, push_slot_d, pop_slot_q, pop_slot_d;
	logic [PW-1:0]  push_prio_q, push_prio_d, pick_prio_q, pick_prio_d;
	logic           pick_after_q, pick_after_d, pop_last_q, pop_last_d;

	logic           rec_we, link_we, head_we, tail_we;
	logic [TW-1:0]  rec_waddr, link_waddr, rec_raddr, link_raddr;
	logic [RW-1:0]  rec_wdata, rec_rdata;
	logic [TW-1:0]  link_wdata, link_rdata, head_wdata, head_rdata, tail_wdata, tail_rdata;
	logic [PW-1:0]  head_waddr, head_raddr, tail_waddr, tail_raddr;

	div_req_t       div_req;
	div_rsp_t       div_rsp;

	logic [QW-1:0]  fresh, requant;
	logic [TW-1:0]  cur_tid, idle_tid;
	logic [PW-1:0]  cur_prio, dec_prio, push_p, pick_p;
	logic           idle_ok, act_is_idle, found;
	logic [16:0]    phase_inc, total;
	logic [15:0]    idle_n, busy_n;

	always_comb begin
		fresh       = (32'(cfg.init_quantum) > QMAX) ? QW'(QMAX) : QW'(cfg.init_quantum);
		cur_tid     = TW'(cur_q.task_id);
		cur_prio    = PW'(cur_q.prio);
		idle_tid    = TW'(cfg.idle_slot);
		idle_ok     = 32'(cfg.idle_slot) < NUM_TASKS;
		act_is_idle = idle_ok && (act_task_q == idle_tid);
		dec_prio    = (act_quant_q == '0 && act_prio_q != '0) ? act_prio_q - PW'(1) : act_prio_q;
		requant     = (act_quant_q == '0) ? fresh : act_quant_q;
		push_p      = (cur_q.cmd == CMD_SCHEDULE) ? dec_prio : cur_prio;
		found       = 1'b0;
		pick_p      = '0;
		// highest set bit wins
		for (int i = 0; i < NQ; i++) begin
			if (qne_q[i]) begin
				found  = 1'b1;
				pick_p = PW'(i);
			end
		end
	end

	always_comb begin
		state_d       = state_q;
		cur_d         = cur_q;
		res_valid_d   = res_valid_q && !res_ready;
		res_status_d  = res_status_q;
		qne_d         = qne_q;
		act_task_d    = act_task_q;
		act_valid_d   = act_valid_q;
		act_prio_d    = act_prio_q;
		act_quant_d   = act_quant_q;
		act_resched_d = act_resched_q;
		wait_d        = wait_q;
		idle_cnt_d    = idle_cnt_q;
		busy_cnt_d    = busy_cnt_q;
		phase_d       = phase_q;
		load_d        = load_q;
		push_slot_d   = push_slot_q;
		push_prio_d   = push_prio_q;
		pick_prio_d   = pick_prio_q;
		pick_after_d  = pick_after_q;
		pop_slot_d    = pop_slot_q;
		pop_last_d    = pop_last_q;
		q_pop         = 1'b0;
		rec_we        = 1'b0;
		rec_waddr     = act_task_q;
		rec_wdata     = {act_prio_q, act_quant_q};
		rec_raddr     = head_rdata;
		link_we       = 1'b0;
		link_waddr    = tail_rdata;
		link_wdata    = push_slot_q;
		link_raddr    = head_rdata;
		head_we       = 1'b0;
		head_waddr    = push_prio_q;
		head_wdata    = push_slot_q;
		head_raddr    = pick_p;
		tail_we       = 1'b0;
		tail_waddr    = push_prio_q;
		tail_wdata    = push_slot_q;
		tail_raddr    = (state_q == S_PICK) ? pick_p : push_p;
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = '0;
		idle_n        = idle_cnt_q;
		busy_n        = busy_cnt_q;
		phase_inc     = 17'(phase_q) + 17'd1;
		total         = '0;

		case (state_q)
			S_IDLE: begin
				if (q_valid && !res_valid_q) begin
					q_pop   = 1'b1;
					cur_d   = q_item;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				res_status_d = ST_OK;
				state_d      = S_IDLE;
				res_valid_d  = 1'b1;
				case (cur_q.cmd)
					CMD_ENQUEUE: begin
						if (cur_q.slot_ok) begin
							rec_we    = 1'b1;
							rec_waddr = cur_tid;
							rec_wdata = {cur_prio, fresh};
							if (act_valid_q && act_task_q == cur_tid) begin
								act_prio_d    = cur_prio;
								act_quant_d   = fresh;
								act_resched_d = 1'b0;
							end else if (act_valid_q && cur_prio > act_prio_q) begin
								act_resched_d = 1'b1;
							end
							push_slot_d  = cur_tid;
							push_prio_d  = cur_prio;
							pick_after_d = 1'b0;
							state_d      = S_PUSH;
							res_valid_d  = 1'b0;
						end
					end
					CMD_SCHEDULE: begin
						if (!act_valid_q) begin
							state_d     = S_PICK;
							res_valid_d = 1'b0;
						end else if (act_resched_q) begin
							// requeue the preempted task, then pick
							rec_we       = 1'b1;
							rec_wdata    = {dec_prio, requant};
							act_valid_d  = 1'b0;
							push_slot_d  = act_task_q;
							push_prio_d  = dec_prio;
							pick_after_d = 1'b1;
							state_d      = S_PUSH;
							res_valid_d  = 1'b0;
						end
					end
					CMD_TICK: begin
						if (act_valid_q) begin
							if (act_quant_q != '0) begin
								act_quant_d = act_quant_q - QW'(1);
								if (act_quant_q == QW'(1)) begin
									act_resched_d = 1'b1;
								end
							end
							if (act_is_idle) begin
								idle_n = idle_cnt_q + 16'd1;
							end else begin
								busy_n = busy_cnt_q + 16'd1;
							end
						end else begin
							idle_n = idle_cnt_q + 16'd1;
						end
						total = 17'(idle_n) + 17'(busy_n);
						if (phase_inc >= 17'(cfg.ticks_per_window)) begin
							// window closed: busy * 100 / total
							div_req.start = 1'b1;
							div_req.num   = 24'(busy_n) * 24'(LOAD_SCALE);
							div_req.den   = total;
							idle_cnt_d    = '0;
							busy_cnt_d    = '0;
							phase_d       = '0;
							state_d       = S_DIV;
							res_valid_d   = 1'b0;
						end else begin
							idle_cnt_d = idle_n;
							busy_cnt_d = busy_n;
							phase_d    = phase_inc[15:0];
						end
					end
					CMD_YIELD: begin
						if (act_valid_q) begin
							act_resched_d = 1'b1;
						end else begin
							res_status_d = ST_NO_ACTIVE;
						end
					end
					CMD_DEQUEUE: begin
						if (!act_valid_q) begin
							res_status_d = ST_NO_ACTIVE;
						end else if (act_is_idle) begin
							res_status_d = ST_IDLE_PROT;
						end else begin
							rec_we      = 1'b1;
							act_valid_d = 1'b0;
						end
					end
					CMD_INSTALL: begin
						if (act_valid_q) begin
							res_status_d = ST_ALREADY;
						end else if (idle_ok) begin
							act_task_d    = idle_tid;
							act_valid_d   = 1'b1;
							act_prio_d    = '0;
							act_quant_d   = fresh;
							act_resched_d = 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
			S_PUSH: begin
				link_we = qne_q[push_prio_q];
				head_we = !qne_q[push_prio_q];
				tail_we = 1'b1;
				qne_d[push_prio_q] = 1'b1;
				if (wait_q != 7'd127) begin
					wait_d = wait_q + 7'd1;
				end
				if (pick_after_q) begin
					state_d = S_PICK;
				end else begin
					res_status_d = ST_OK;
					res_valid_d  = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_PICK: begin
				if (!found) begin
					res_status_d = ST_EMPTY;
					res_valid_d  = 1'b1;
					state_d      = S_IDLE;
				end else begin
					pick_prio_d = pick_p;
					state_d     = S_POP1;
				end
			end
			S_POP1: begin
				pop_slot_d = head_rdata;
				pop_last_d = head_rdata == tail_rdata;
				if (head_rdata == tail_rdata) begin
					qne_d[pick_prio_q] = 1'b0;
				end
				if (wait_q != 7'd0) begin
					wait_d = wait_q - 7'd1;
				end
				state_d = S_POP2;
			end
			S_POP2: begin
				head_we       = !pop_last_q;
				head_waddr    = pick_prio_q;
				head_wdata    = link_rdata;
				act_task_d    = pop_slot_q;
				act_valid_d   = 1'b1;
				act_prio_d    = rec_rdata[RW-1:QW];
				act_quant_d   = rec_rdata[QW-1:0];
				act_resched_d = 1'b0;
				res_status_d  = ST_OK;
				res_valid_d   = 1'b1;
				state_d       = S_IDLE;
			end
			S_DIV: begin
				if (div_rsp.done) begin
					load_d       = div_rsp.quot;
					res_status_d = ST_OK;
					res_valid_d  = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cur_q         <= '0;
			res_valid_q   <= 1'b0;
			res_status_q  <= ST_OK;
			qne_q         <= '0;
			act_task_q    <= '0;
			act_valid_q   <= 1'b0;
			act_prio_q    <= '0;
			act_quant_q   <= '0;
			act_resched_q <= 1'b0;
			wait_q        <= '0;
			idle_cnt_q    <= '0;
			busy_cnt_q    <= '0;
			phase_q       <= '0;
			load_q        <= '0;
			push_slot_q   <= '0;
			push_prio_q   <= '0;
			pick_prio_q   <= '0;
			pick_after_q  <= 1'b0;
			pop_slot_q    <= '0;
			pop_last_q    <= 1'b0;
		end else begin
			state_q       <= state_d;
			cur_q         <= cur_d;
			res_valid_q   <= res_valid_d;
			res_status_q  <= res_status_d;
			qne_q         <= qne_d;
			act_task_q    <= act_task_d;
			act_valid_q   <= act_valid_d;
			act_prio_q    <= act_prio_d;
			act_quant_q   <= act_quant_d;
			act_resched_q <= act_resched_d;
			wait_q        <= wait_d;
			idle_cnt_q    <= idle_cnt_d;
			busy_cnt_q    <= busy_cnt_d;
			phase_q       <= phase_d;
			load_q        <= load_d;
			push_slot_q   <= push_slot_d;
			push_prio_q   <= push_prio_d;
			pick_prio_q   <= pick_prio_d;
			pick_after_q  <= pick_after_d;
			pop_slot_q    <= pop_slot_d;
			pop_last_q    <= pop_last_d;
		end
	end

	// per-slot {priority, quantum}; the active task's copy lives in act_*_q
	mfts_ram #(.WIDTH(RW), .DEPTH(NUM_TASKS)) u_rec (
		.clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
		.raddr(rec_raddr), .rdata(rec_rdata)
	);
	mfts_ram #(.WIDTH(TW), .DEPTH(NUM_TASKS)) u_link (
		.clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
		.raddr(link_raddr), .rdata(link_rdata)
	);
	mfts_ram #(.WIDTH(TW), .DEPTH(NQ)) u_head (
		.clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
		.raddr(head_raddr), .rdata(head_rdata)
	);
	mfts_ram #(.WIDTH(TW), .DEPTH(NQ)) u_tail (
		.clk(clk), .we(tail_we), .waddr(tail_waddr), .wdata(tail_wdata),
		.raddr(tail_raddr), .rdata(tail_rdata)
	);

	mfts_div u_div (
		.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp)
	);

	assign res_valid              = res_valid_q;
	assign res.status             = res_status_q;
	assign res.task_out           = act_valid_q ? 6'(act_task_q) : 6'd0;
	assign res.task_valid         = act_valid_q;
	assign res.ready_count        = wait_q;
	assign res.load_percent       = load_q;
	assign res.reschedule_pending = act_valid_q && act_resched_q;

	`MFTS_ASSERT_IMPL(a_hold_while_result, res_valid_q, state_q == S_IDLE, "work while result held")
	`MFTS_ASSERT_IMPL(a_div_alive, state_q == S_DIV, div_rsp.busy || div_rsp.done, "divider stalled")
	`MFTS_ASSERT_IMPL(a_pop_nonempty, state_q == S_POP1, qne_q[pick_prio_q], "pop of empty queue")
endmodule

@@ design/multilevel_feedback_task_scheduler.sv @@
// Top level of the multilevel feedback task scheduler.
// Depends on mfts_pkg, mfts_front, mfts_back (with mfts_ram, mfts_div).
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata: cmd, task_id, priority_req
// m_*       out  m_tvalid/m_tready  m_tdata: status .. reschedule_pending
// cfg_*     in   cfg_valid/ready    cfg_index, cfg_data
//
// Back-end states per command, excluding queue wait: yield, dequeue, install,
// plain tick: exec; enqueue: exec, push; schedule: exec, maybe push, pick,
// pop1, pop2 (table RAM reads, one registered read per step); window end: div.
// Reset clears all control state; the task and queue tables need no clearing.
// Input keeps flowing into a two-entry queue while a result waits on m_tready.
module multilevel_feedback_task_scheduler #(
	parameter int unsigned NUM_TASKS    = 64,
	parameter int unsigned MAX_PRIORITY = 15,
	parameter int unsigned QUANTUM_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // cmd[2:0], task_id[8:3], priority_req[12:9], zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // status[2:0], task_out[8:3], task_valid[9],
	                               // ready count[16:10], load_percent[23:17],
	                               // reschedule_pending[24], zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import mfts_pkg::*;

	cfg_t  cfg_q;
	logic  q_valid, q_pop;
	item_t q_item;
	res_t  res;

	// config is always taken; the host writes only while no command is in flight
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_slot        <= 6'd0;
			cfg_q.init_quantum     <= 8'd10;
			cfg_q.ticks_per_window <= 16'd100;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_IDLE_SLOT:    cfg_q.idle_slot        <= cfg_data[5:0];
				CFG_INIT_QUANTUM: cfg_q.init_quantum     <= cfg_data[7:0];
				CFG_TICKS_WINDOW: cfg_q.ticks_per_window <= cfg_data;
				default:          cfg_q                  <= cfg_q;
			endcase
		end
	end

	mfts_front #(.NUM_TASKS(NUM_TASKS), .MAX_PRIORITY(MAX_PRIORITY)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	mfts_back #(
		.NUM_TASKS(NUM_TASKS), .MAX_PRIORITY(MAX_PRIORITY), .QUANTUM_BITS(QUANTUM_BITS)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.cfg(cfg_q),
		.res_valid(m_tvalid), .res_ready(m_tready), .res(res)
	);

	assign m_tdata = {7'd0, res.reschedule_pending, res.load_percent, res.ready_count,
		res.task_valid, res.task_out, res.status};
endmodule
